@@ rtl/blcq_pkg.sv @@
package blcq_pkg;

    // Default sizes of the block pool and the queue set
    localparam int POOL_BLOCKS_DEF = 64;
    localparam int BLOCK_BYTES_DEF = 64;
    localparam int NUM_QUEUES_DEF  = 4;

    // Field widths of the request and response items
    localparam int REQ_W    = 2;
    localparam int QID_W    = 2;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int QCNT_W   = 13;
    localparam int BIU_W    = 7;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_GET   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FLUSH = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [QID_W-1:0]  queue_id;
        logic [BYTE_W-1:0] put_byte;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   get_byte;
        logic [STATUS_W-1:0] status;
        logic [QCNT_W-1:0]   queue_count;
        logic [BIU_W-1:0]    blocks_in_use;
    } out_item_t;

endpackage

@@ rtl/blcq_ram.sv @@
module blcq_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word, read one word with registered output
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/block_linked_char_queues.sv @@
// Character queues over a shared pool of fixed-size blocks.
//
// Request channel (req_valid / req_stall / req): each item names a queue and
// asks to put a byte, get a byte or flush the queue. Response channel
// (rsp_valid / rsp_stall / rsp): exactly one item per request, in order, with
// the removed byte, a status, the queue's byte count and the pool usage.
// Requests are handled one at a time by a small sequencer around four
// single-port-write RAMs (queue records, block links, block read/write
// positions, byte store); every pointer access costs one registered read.
// Each request first reads its queue record in S_QRD, and its response is
// registered in S_DONE. A put into a queue with a tail block reads the
// block positions in S_PUT_POS and appends there if the block has room; a
// put that needs a new block pops it in S_ALLOC and, behind a full tail,
// links it in S_LINK. A get reads the positions in S_GET_POS and the byte
// in S_GET_BYTE, and frees a drained block in S_GET_FREE. A flush, a no-op,
// an empty get or a refused put into an empty queue goes straight to S_DONE.
// A new request is taken only back in S_IDLE. After reset a clearing pass
// builds the free list and empties the queues, with req_stall high. A stalled
// response stays in the output register; the next request is still taken,
// and its response waits until the register frees.
module block_linked_char_queues
    import blcq_pkg::*;
#(
    parameter int POOL_BLOCKS = POOL_BLOCKS_DEF,
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
    parameter int NUM_QUEUES  = NUM_QUEUES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  in_item_t  req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output out_item_t rsp
);

    // Derived widths
    localparam int LAW     = $clog2(POOL_BLOCKS);
    localparam int BW      = $clog2(POOL_BLOCKS + 1);
    localparam int PW      = $clog2(BLOCK_BYTES + 1);
    localparam int AW      = $clog2(POOL_BLOCKS * BLOCK_BYTES);
    localparam int CNTW    = $clog2(POOL_BLOCKS * BLOCK_BYTES + 1);
    localparam int QW      = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int CLR_LEN = (POOL_BLOCKS > NUM_QUEUES) ? POOL_BLOCKS : NUM_QUEUES;
    localparam int CLW     = $clog2(CLR_LEN);

    localparam logic [BW-1:0] NIL = BW'(POOL_BLOCKS);

    // Sequencer states
    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_QRD      = 4'd2;
    localparam logic [3:0] S_PUT_POS  = 4'd3;
    localparam logic [3:0] S_ALLOC    = 4'd4;
    localparam logic [3:0] S_LINK     = 4'd5;
    localparam logic [3:0] S_GET_POS  = 4'd6;
    localparam logic [3:0] S_GET_BYTE = 4'd7;
    localparam logic [3:0] S_GET_FREE = 4'd8;
    localparam logic [3:0] S_DONE     = 4'd9;

    typedef struct packed {
        logic [BW-1:0]   head;
        logic [BW-1:0]   tail;
        logic [CNTW-1:0] bytes;
        logic [BW-1:0]   nblk;
    } qrec_t;

    typedef struct packed {
        logic [PW-1:0] rd;
        logic [PW-1:0] wr;
    } pos_t;

    function automatic logic is_blk(input logic [BW-1:0] b);
        return 32'(b) < POOL_BLOCKS;
    endfunction

    function automatic logic [AW-1:0] byte_addr(input logic [BW-1:0] b,
                                                input logic [PW-1:0] p);
        return AW'(b) * AW'(BLOCK_BYTES) + AW'(p);
    endfunction

    // Control and working registers
    logic [3:0]          state_reg, state_next;
    logic [CLW-1:0]      clr_reg, clr_next;
    in_item_t            req_reg, req_next;
    logic [QW-1:0]       qaddr_reg, qaddr_next;
    logic                qok_reg, qok_next;
    logic [BW-1:0]       head_reg, head_next;
    logic [BW-1:0]       tail_reg, tail_next;
    logic [CNTW-1:0]     bytes_reg, bytes_next;
    logic [BW-1:0]       nblk_reg, nblk_next;
    logic [PW-1:0]       rd_reg, rd_next;
    logic [PW-1:0]       wr_reg, wr_next;
    logic [BW-1:0]       newb_reg, newb_next;
    logic [BYTE_W-1:0]   got_reg, got_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [BW-1:0]       free_head_reg, free_head_next;
    logic [BW-1:0]       free_tail_reg, free_tail_next;
    logic [BW-1:0]       used_reg, used_next;
    logic                out_valid_reg, out_valid_next;
    out_item_t           out_item_reg, out_item_next;

    // RAM ports
    logic          q_we;
    logic [QW-1:0] q_waddr, q_raddr;
    qrec_t         q_wdata, q_rdata;

    logic           link_we;
    logic [LAW-1:0] link_waddr, link_raddr;
    logic [BW-1:0]  link_wdata, link_rdata;

    logic           pos_we;
    logic [LAW-1:0] pos_waddr, pos_raddr;
    pos_t           pos_wdata, pos_rdata;

    logic              byte_we;
    logic [AW-1:0]     byte_waddr, byte_raddr;
    logic [BYTE_W-1:0] byte_wdata, byte_rdata;

    blcq_ram #(.WIDTH($bits(qrec_t)), .DEPTH(NUM_QUEUES), .ADDR_W(QW)) u_qram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    blcq_ram #(.WIDTH(BW), .DEPTH(POOL_BLOCKS), .ADDR_W(LAW)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    blcq_ram #(.WIDTH($bits(pos_t)), .DEPTH(POOL_BLOCKS), .ADDR_W(LAW)) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    blcq_ram #(.WIDTH(BYTE_W), .DEPTH(POOL_BLOCKS * BLOCK_BYTES), .ADDR_W(AW)) u_byte_ram (
        .clk   (clk),
        .we    (byte_we),
        .waddr (byte_waddr),
        .wdata (byte_wdata),
        .raddr (byte_raddr),
        .rdata (byte_rdata)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_item_reg;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        req_next       = req_reg;
        qaddr_next     = qaddr_reg;
        qok_next       = qok_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        bytes_next     = bytes_reg;
        nblk_next      = nblk_reg;
        rd_next        = rd_reg;
        wr_next        = wr_reg;
        newb_next      = newb_reg;
        got_next       = got_reg;
        status_next    = status_reg;
        free_head_next = free_head_reg;
        free_tail_next = free_tail_reg;
        used_next      = used_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;

        q_we       = 1'b0;
        q_waddr    = qaddr_reg;
        q_wdata    = '{head: head_reg, tail: tail_reg, bytes: bytes_reg, nblk: nblk_reg};
        q_raddr    = QW'(req.queue_id);
        link_we    = 1'b0;
        link_waddr = newb_reg[LAW-1:0];
        link_wdata = NIL;
        link_raddr = free_head_reg[LAW-1:0];
        pos_we     = 1'b0;
        pos_waddr  = head_reg[LAW-1:0];
        pos_wdata  = '{rd: rd_reg, wr: wr_reg};
        pos_raddr  = head_reg[LAW-1:0];
        byte_we    = 1'b0;
        byte_waddr = byte_addr(newb_reg, '0);
        byte_wdata = req_reg.put_byte;
        byte_raddr = byte_addr(head_reg, rd_reg);

        // Drop the response once taken
        if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                // Chain blocks into the free list, empty the queues
                link_we    = (32'(clr_reg) < POOL_BLOCKS);
                link_waddr = clr_reg[LAW-1:0];
                link_wdata = BW'(32'(clr_reg) + 32'd1);
                q_we       = (32'(clr_reg) < NUM_QUEUES);
                q_waddr    = clr_reg[QW-1:0];
                q_wdata    = '{head: NIL, tail: NIL, bytes: '0, nblk: '0};
                if (32'(clr_reg) == CLR_LEN - 1)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                // Take a request, read its queue record
                if (req_valid)
                begin
                    req_next    = req;
                    qaddr_next  = QW'(req.queue_id);
                    qok_next    = (32'(req.queue_id) < NUM_QUEUES);
                    got_next    = '0;
                    status_next = ST_OK;
                    state_next  = S_QRD;
                end
            end

            S_QRD:
            begin
                head_next  = q_rdata.head;
                tail_next  = q_rdata.tail;
                bytes_next = q_rdata.bytes;
                nblk_next  = q_rdata.nblk;
                state_next = S_DONE;
                if (qok_reg)
                begin
                    unique case (req_reg.req_type)
                        REQ_PUT:
                        begin
                            if (is_blk(q_rdata.tail))
                            begin
                                pos_raddr  = q_rdata.tail[LAW-1:0];
                                state_next = S_PUT_POS;
                            end
                            else if (!is_blk(free_head_reg))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                link_raddr = free_head_reg[LAW-1:0];
                                newb_next  = free_head_reg;
                                state_next = S_ALLOC;
                            end
                        end
                        REQ_GET:
                        begin
                            if (!is_blk(q_rdata.head) || q_rdata.bytes == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                pos_raddr  = q_rdata.head[LAW-1:0];
                                state_next = S_GET_POS;
                            end
                        end
                        REQ_FLUSH:
                        begin
                            // Splice the whole chain onto the free list
                            if (is_blk(q_rdata.head) && is_blk(q_rdata.tail))
                            begin
                                link_we        = 1'b1;
                                link_waddr     = q_rdata.tail[LAW-1:0];
                                link_wdata     = free_head_reg;
                                if (!is_blk(free_head_reg))
                                begin
                                    free_tail_next = q_rdata.tail;
                                end
                                free_head_next = q_rdata.head;
                                used_next      = (used_reg >= q_rdata.nblk) ?
                                                 used_reg - q_rdata.nblk : '0;
                            end
                            head_next  = NIL;
                            tail_next  = NIL;
                            bytes_next = '0;
                            nblk_next  = '0;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_PUT_POS:
            begin
                rd_next = pos_rdata.rd;
                wr_next = pos_rdata.wr;
                if (32'(pos_rdata.wr) >= BLOCK_BYTES)
                begin
                    // Tail block full: open a fresh one, or refuse if the pool is empty
                    if (!is_blk(free_head_reg))
                    begin
                        status_next = ST_FULL;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        link_raddr = free_head_reg[LAW-1:0];
                        newb_next  = free_head_reg;
                        state_next = S_ALLOC;
                    end
                end
                else
                begin
                    // Append into the tail block
                    byte_we    = 1'b1;
                    byte_waddr = byte_addr(tail_reg, pos_rdata.wr);
                    pos_we     = 1'b1;
                    pos_waddr  = tail_reg[LAW-1:0];
                    pos_wdata  = '{rd: pos_rdata.rd, wr: pos_rdata.wr + 1'b1};
                    bytes_next = bytes_reg + 1'b1;
                    state_next = S_DONE;
                end
            end

            S_ALLOC:
            begin
                // Pop the free list, write the first byte of the new block
                free_head_next = link_rdata;
                if (!is_blk(link_rdata))
                begin
                    free_tail_next = NIL;
                end
                link_we    = 1'b1;
                link_waddr = newb_reg[LAW-1:0];
                link_wdata = NIL;
                pos_we     = 1'b1;
                pos_waddr  = newb_reg[LAW-1:0];
                pos_wdata  = '{rd: '0, wr: PW'(1)};
                byte_we    = 1'b1;
                byte_waddr = byte_addr(newb_reg, '0);
                used_next  = used_reg + 1'b1;
                bytes_next = bytes_reg + 1'b1;
                nblk_next  = nblk_reg + 1'b1;
                if (is_blk(tail_reg))
                begin
                    state_next = S_LINK;
                end
                else
                begin
                    head_next  = newb_reg;
                    tail_next  = newb_reg;
                    state_next = S_DONE;
                end
            end

            S_LINK:
            begin
                // Hang the new block behind the old tail
                link_we    = 1'b1;
                link_waddr = tail_reg[LAW-1:0];
                link_wdata = newb_reg;
                tail_next  = newb_reg;
                state_next = S_DONE;
            end

            S_GET_POS:
            begin
                rd_next    = pos_rdata.rd;
                wr_next    = pos_rdata.wr;
                byte_raddr = byte_addr(head_reg, pos_rdata.rd);
                state_next = S_GET_BYTE;
            end

            S_GET_BYTE:
            begin
                got_next   = byte_rdata;
                bytes_next = bytes_reg - 1'b1;
                rd_next    = rd_reg + 1'b1;
                pos_we     = 1'b1;
                pos_waddr  = head_reg[LAW-1:0];
                pos_wdata  = '{rd: rd_reg + 1'b1, wr: wr_reg};
                if ((rd_reg + 1'b1) >= wr_reg)
                begin
                    link_raddr = head_reg[LAW-1:0];
                    state_next = S_GET_FREE;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_GET_FREE:
            begin
                // Advance the head, push the drained block on the free list
                head_next = link_rdata;
                if (!is_blk(link_rdata))
                begin
                    tail_next = NIL;
                end
                link_we    = 1'b1;
                link_waddr = head_reg[LAW-1:0];
                link_wdata = free_head_reg;
                if (!is_blk(free_head_reg))
                begin
                    free_tail_next = head_reg;
                end
                free_head_next = head_reg;
                used_next      = (used_reg != '0) ? used_reg - 1'b1 : used_reg;
                nblk_next      = nblk_reg - 1'b1;
                state_next     = S_DONE;
            end

            S_DONE:
            begin
                // Write back the queue record, hand out the response item
                q_we = qok_reg;
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_valid_next = 1'b1;
                    out_item_next  = '{
                        get_byte:      got_reg,
                        status:        status_reg,
                        queue_count:   qok_reg ? QCNT_W'(bytes_reg) : '0,
                        blocks_in_use: BIU_W'(used_reg)
                    };
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            free_head_reg <= '0;
            free_tail_reg <= BW'(POOL_BLOCKS - 1);
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            free_head_reg <= free_head_next;
            free_tail_reg <= free_tail_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        qaddr_reg    <= qaddr_next;
        qok_reg      <= qok_next;
        head_reg     <= head_next;
        tail_reg     <= tail_next;
        bytes_reg    <= bytes_next;
        nblk_reg     <= nblk_next;
        rd_reg       <= rd_next;
        wr_reg       <= wr_next;
        newb_reg     <= newb_next;
        got_reg      <= got_next;
        status_reg   <= status_next;
        out_item_reg <= out_item_next;
    end

endmodule

@@ rtl/blcq_checker.sv @@
module blcq_checker
    import blcq_pkg::*;
#(
    parameter int POOL_BLOCKS = POOL_BLOCKS_DEF
) (
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_stall,
    input in_item_t  req,
    input logic      rsp_valid,
    input logic      rsp_stall,
    input out_item_t rsp
);

    // Hold a stalled response item
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled response item changed or dropped");

    // One request at a time: stall right after a request is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while the previous one is in work");

    // An empty get carries no byte and reports an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_EMPTY |-> rsp.get_byte == '0 && rsp.queue_count == '0)
        else $error("empty get with byte or count");

    // Pool exhaustion only with every block in use
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_FULL |-> rsp.blocks_in_use == BIU_W'(POOL_BLOCKS))
        else $error("pool exhausted with free blocks left");

endmodule

bind block_linked_char_queues blcq_checker #(.POOL_BLOCKS(POOL_BLOCKS)) u_blcq_checker (.*);
